// ===== hdl/rds_pkg.sv =====
package rds_pkg;

  localparam logic [2:0] CMD_MAT   = 3'd0;
  localparam logic [2:0] CMD_INV   = 3'd1;
  localparam logic [2:0] CMD_DINV  = 3'd2;
  localparam logic [2:0] CMD_DET   = 3'd3;
  localparam logic [2:0] CMD_CLAMP = 3'd4;

  localparam logic [1:0] REG_ROT0  = 2'd0;
  localparam logic [1:0] REG_ROT1  = 2'd1;
  localparam logic [1:0] REG_ROT2  = 2'd2;
  localparam logic [1:0] REG_FLOOR = 2'd3;

  localparam logic [47:0] ROT0_RST  = 48'd16384;
  localparam logic [47:0] ROT1_RST  = 48'd1073741824;
  localparam logic [47:0] ROT2_RST  = 48'd70368744177664;
  localparam logic [30:0] FLOOR_RST = 31'd66;

  // long division: 65-bit dividend, 62-bit divisor
  localparam int Q_W         = 65;
  localparam int DEN_W       = 62;
  localparam int REM_W       = 63;
  localparam int DIV_BITS    = 5;
  localparam int DIV_STAGES  = Q_W / DIV_BITS;
  localparam int RECIP_SHIFT = 48;
  localparam int DINV_SHIFT  = 64;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic [1:0]         deriv_index;
    logic signed [31:0] floor_value;
  } req_t;

  typedef struct packed {
    logic signed [63:0] word0;
    logic signed [63:0] word1;
    logic signed [63:0] word2;
    logic signed [63:0] word3;
    logic signed [63:0] word4;
    logic signed [63:0] word5;
  } rsp_t;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [1:0]       idx;
    logic [2:0][31:0] s;
    logic [31:0]      fl;
    logic             vone;
  } side_t;

  typedef logic [2:0][5:0][31:0] rprod_t;
  typedef logic [2:0][Q_W-1:0]   quo_t;

  // matrix entry order xx, yy, zz, xy, xz, yz
  function automatic int ent_a(input int e);
    case (e)
      1: return 1;
      2: return 2;
      5: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic int ent_b(input int e);
    case (e)
      1: return 1;
      2: return 2;
      3: return 1;
      4: return 2;
      5: return 2;
      default: return 0;
    endcase
  endfunction

  // round half up, arithmetic shift right by n, saturate to 64 bits
  function automatic logic [63:0] round_sat(input logic signed [97:0] w, input int n);
    logic signed [97:0] t;
    t = (w + (98'sd1 <<< (n - 1))) >>> n;
    if ((&t[97:63]) || !(|t[97:63])) begin
      return t[63:0];
    end
    return t[97] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  endfunction

endpackage

// ===== hdl/rds_front.sv =====
module rds_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 req_valid,
  input  rds_pkg::req_t                        req,
  input  logic [30:0]                          zero_floor,
  output logic                                 out_valid,
  output rds_pkg::side_t                       side,
  output logic [2:0][rds_pkg::Q_W-1:0]         num,
  output logic [2:0][rds_pkg::DEN_W-1:0]       den
);

  logic          v1;
  rds_pkg::req_t r1;

  logic [30:0]       zf;
  logic [2:0][31:0]  s1;
  logic [2:0][30:0]  vf;
  logic [30:0]       vsel;

  logic [2:0][30:0]  vf2;
  logic [61:0]       vv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
    end
    if (en) begin
      r1 <= req;
    end
  end

  // floor each stretch before any reciprocal; a zero floor acts as one LSB
  always_comb begin
    zf = (zero_floor == '0) ? 31'd1 : zero_floor;
    s1[0] = r1.scale_x;
    s1[1] = r1.scale_y;
    s1[2] = r1.scale_z;
    for (int k = 0; k < 3; k++) begin
      vf[k] = ($signed(s1[k]) < $signed({1'b0, zf})) ? zf : s1[k][30:0];
    end
    case (r1.deriv_index)
      2'd0: vsel = vf[0];
      2'd1: vsel = vf[1];
      2'd2: vsel = vf[2];
      default: vsel = 31'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      side.cmd  <= r1.cmd;
      side.idx  <= r1.deriv_index;
      side.s    <= s1;
      side.fl   <= r1.floor_value;
      side.vone <= (vsel == 31'd1);
      vf2       <= vf;
      vv2       <= vsel * vsel;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = '0;
      den[k] = rds_pkg::DEN_W'(1);
      if (side.cmd == rds_pkg::CMD_INV) begin
        num[k] = (rds_pkg::Q_W'(1) << rds_pkg::RECIP_SHIFT) + rds_pkg::Q_W'(vf2[k] >> 1);
        den[k] = rds_pkg::DEN_W'(vf2[k]);
      end else if (side.cmd == rds_pkg::CMD_DINV && side.idx == 2'(k)) begin
        num[k] = (rds_pkg::Q_W'(1) << rds_pkg::DINV_SHIFT) + rds_pkg::Q_W'(vv2 >> 1);
        den[k] = vv2;
      end
    end
  end

endmodule

// ===== hdl/rds_div.sv =====
module rds_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rds_pkg::Q_W-1:0]     num,
  input  logic [rds_pkg::DEN_W-1:0]   den,
  output logic [rds_pkg::Q_W-1:0]     quo
);

  localparam int ST = rds_pkg::DIV_STAGES;
  localparam int QW = rds_pkg::Q_W;
  localparam int RW = rds_pkg::REM_W;
  localparam int DW = rds_pkg::DEN_W;

  logic [ST-1:0][QW-1:0] nq;
  logic [ST-2:0][RW-1:0] rem;
  logic [ST-2:0][DW-1:0] dd;

  for (genvar j = 0; j < ST; j++) begin : g_st
    logic [QW-1:0] nq_in;
    logic [RW-1:0] rem_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] nq_o;
    logic [RW-1:0] rem_o;

    if (j == 0) begin : g_first
      assign nq_in  = num;
      assign rem_in = '0;
      assign d_in   = den;
    end else begin : g_next
      assign nq_in  = nq[j-1];
      assign rem_in = rem[j-1];
      assign d_in   = dd[j-1];
    end

    // restoring division, several quotient bits per stage
    always_comb begin
      logic [RW:0] t;
      nq_o  = nq_in;
      rem_o = rem_in;
      for (int b = 0; b < rds_pkg::DIV_BITS; b++) begin
        t    = {rem_o, nq_o[QW-1]};
        nq_o = {nq_o[QW-2:0], 1'b0};
        if (t >= (RW + 1)'(d_in)) begin
          t       = t - (RW + 1)'(d_in);
          nq_o[0] = 1'b1;
        end
        rem_o = t[RW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq[j] <= nq_o;
      end
    end

    if (j < ST - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j] <= rem_o;
          dd[j]  <= d_in;
        end
      end
    end
  end

  assign quo = nq[ST-1];

endmodule

// ===== hdl/rds_tail.sv =====
module rds_tail (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  rds_pkg::side_t  side,
  input  rds_pkg::quo_t   quo,
  input  rds_pkg::rprod_t rp,
  output logic            out_valid,
  output rds_pkg::rsp_t   rsp
);

  // stage 1: diagonal values
  logic             v1;
  logic [2:0]       c1;
  logic [2:0][31:0] s1;
  logic [31:0]      f1;
  logic [2:0][63:0] d1;

  // stage 2: partial products
  logic             v2;
  logic [2:0]       c2;
  logic [2:0][31:0] s2;
  logic [31:0]      f2;
  logic [2:0][5:0][64:0] pl2;
  logic [2:0][5:0][63:0] ph2;
  logic [63:0]      g01_2, g02_2, g12_2;

  // stage 3: sums
  logic             v3;
  logic [2:0]       c3;
  logic [2:0][31:0] s3;
  logic [31:0]      f3;
  logic [5:0][97:0] acc3;
  logic [64:0]      dpl3;
  logic [63:0]      dph3;
  logic [63:0]      g01_3, g02_3, g12_3;

  // stage 4: rounding of the matrix
  logic             v4;
  logic [2:0]       c4;
  logic [2:0][31:0] s4;
  logic [31:0]      f4;
  logic [5:0][63:0] mw4;
  logic [97:0]      det4;
  logic [63:0]      g01_4, g02_4, g12_4;

  logic [5:0][63:0] wsel;
  logic [2:0][31:0] cl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (en) begin
      c1 <= side.cmd;
      s1 <= side.s;
      f1 <= side.fl;
      for (int k = 0; k < 3; k++) begin
        case (side.cmd)
          rds_pkg::CMD_MAT:  d1[k] <= {{16{side.s[k][31]}}, side.s[k], 16'd0};
          rds_pkg::CMD_INV:  d1[k] <= quo[k][63:0];
          rds_pkg::CMD_DINV: begin
            if (side.idx != 2'(k)) begin
              d1[k] <= '0;
            end else if (side.vone) begin
              d1[k] <= 64'h8000_0000_0000_0000;
            end else begin
              d1[k] <= 64'd0 - quo[k][63:0];
            end
          end
          default: d1[k] <= '0;
        endcase
      end

      c2 <= c1;
      s2 <= s1;
      f2 <= f1;
      for (int k = 0; k < 3; k++) begin
        for (int e = 0; e < 6; e++) begin
          pl2[k][e] <= $signed({1'b0, d1[k][31:0]}) * $signed(rp[k][e]);
          ph2[k][e] <= $signed(d1[k][63:32]) * $signed(rp[k][e]);
        end
      end
      g01_2 <= $signed(s1[0]) * $signed(s1[1]);
      g02_2 <= $signed(s1[0]) * $signed(s1[2]);
      g12_2 <= $signed(s1[1]) * $signed(s1[2]);

      c3 <= c2;
      s3 <= s2;
      f3 <= f2;
      for (int e = 0; e < 6; e++) begin
        acc3[e] <= {{2{ph2[0][e][63]}}, ph2[0][e], 32'd0} + {{33{pl2[0][e][64]}}, pl2[0][e]}
                 + {{2{ph2[1][e][63]}}, ph2[1][e], 32'd0} + {{33{pl2[1][e][64]}}, pl2[1][e]}
                 + {{2{ph2[2][e][63]}}, ph2[2][e], 32'd0} + {{33{pl2[2][e][64]}}, pl2[2][e]};
      end
      dpl3  <= $signed({1'b0, g01_2[31:0]}) * $signed(s2[2]);
      dph3  <= $signed(g01_2[63:32]) * $signed(s2[2]);
      g01_3 <= g01_2;
      g02_3 <= g02_2;
      g12_3 <= g12_2;

      c4 <= c3;
      s4 <= s3;
      f4 <= f3;
      for (int e = 0; e < 6; e++) begin
        mw4[e] <= rds_pkg::round_sat($signed(acc3[e]), 28);
      end
      det4  <= {{2{dph3[63]}}, dph3, 32'd0} + {{33{dpl3[64]}}, dpl3};
      g01_4 <= g01_3;
      g02_4 <= g02_3;
      g12_4 <= g12_3;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cl[k] = ($signed(s4[k]) < $signed(f4)) ? f4 : s4[k];
    end
    wsel = '0;
    case (c4)
      rds_pkg::CMD_MAT, rds_pkg::CMD_INV, rds_pkg::CMD_DINV: wsel = mw4;
      rds_pkg::CMD_DET: begin
        wsel[0] = rds_pkg::round_sat($signed(det4), 16);
        wsel[1] = g12_4;
        wsel[2] = g02_4;
        wsel[3] = g01_4;
      end
      rds_pkg::CMD_CLAMP: begin
        for (int k = 0; k < 3; k++) begin
          wsel[k] = {{16{cl[k][31]}}, cl[k], 16'd0};
        end
      end
      default: wsel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
    if (en) begin
      rsp.word0 <= wsel[0];
      rsp.word1 <= wsel[1];
      rsp.word2 <= wsel[2];
      rsp.word3 <= wsel[3];
      rsp.word4 <= wsel[4];
      rsp.word5 <= wsel[5];
    end
  end

endmodule

// ===== hdl/rotated_diagonal_stretch_unit_core.sv =====
// Streaming unit: one request enters per clock while req_stall is low; its single result
// passes through 2 front stages for flooring and squaring, 13 stages of 65-bit long division
// at 5 quotient bits each, and 5 stages of multiply, sum, round and select. Throughput is one
// request per cycle whatever the command, while not stalled. A stalled result freezes the
// whole pipeline. Registers sit on an APB port at byte addresses 0, 8, 16 and 24 with
// 64-bit data; write them only while no request is in flight.
module rotated_diagonal_stretch_unit_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rds_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rds_pkg::rsp_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  localparam int ST = rds_pkg::DIV_STAGES;

  logic [47:0] rot0, rot1, rot2;
  logic [30:0] zero_floor;
  logic        en;

  rds_pkg::rprod_t rp;
  logic [2:0][47:0] rows;

  logic                                 fv;
  rds_pkg::side_t                       fside;
  logic [2:0][rds_pkg::Q_W-1:0]         num;
  logic [2:0][rds_pkg::DEN_W-1:0]       den;
  rds_pkg::quo_t                        quo;

  logic [ST-1:0]                        sv;
  rds_pkg::side_t                       sd [ST];

  assign pready    = 1'b1;
  assign en        = !rsp_valid || !rsp_stall;
  assign req_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot0       <= rds_pkg::ROT0_RST;
      rot1       <= rds_pkg::ROT1_RST;
      rot2       <= rds_pkg::ROT2_RST;
      zero_floor <= rds_pkg::FLOOR_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        rds_pkg::REG_ROT0:  rot0       <= pwdata[47:0];
        rds_pkg::REG_ROT1:  rot1       <= pwdata[47:0];
        rds_pkg::REG_ROT2:  rot2       <= pwdata[47:0];
        rds_pkg::REG_FLOOR: zero_floor <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      rds_pkg::REG_ROT0:  prdata = {16'd0, rot0};
      rds_pkg::REG_ROT1:  prdata = {16'd0, rot1};
      rds_pkg::REG_ROT2:  prdata = {16'd0, rot2};
      rds_pkg::REG_FLOOR: prdata = {33'd0, zero_floor};
      default:            prdata = '0;
    endcase
  end

  // rotation products R[k][a] * R[k][b], refreshed every cycle from the registers
  assign rows = {rot2, rot1, rot0};

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int e = 0; e < 6; e++) begin
        rp[k][e] <= $signed(rows[k][16 * rds_pkg::ent_a(e) +: 16])
                  * $signed(rows[k][16 * rds_pkg::ent_b(e) +: 16]);
      end
    end
  end

  rds_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .req_valid  (req_valid),
    .req        (req),
    .zero_floor (zero_floor),
    .out_valid  (fv),
    .side       (fside),
    .num        (num),
    .den        (den)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    rds_div u_div (
      .clk (clk),
      .en  (en),
      .num (num[k]),
      .den (den[k]),
      .quo (quo[k])
    );
  end

  // carry the rest of the request alongside the division
  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (en) begin
      sv <= {sv[ST-2:0], fv};
    end
    if (en) begin
      sd[0] <= fside;
      for (int j = 1; j < ST; j++) begin
        sd[j] <= sd[j-1];
      end
    end
  end

  rds_tail u_tail (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sv[ST-1]),
    .side      (sd[ST-1]),
    .quo       (quo),
    .rp        (rp),
    .out_valid (rsp_valid),
    .rsp       (rsp)
  );

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(sv))
    else $error("pipeline valid bits moved while stalled");

  a_recip_range: assert property (@(posedge clk) disable iff (rst)
    sv[ST-1] && sd[ST-1].cmd == rds_pkg::CMD_INV |-> quo[0][64:49] == '0)
    else $error("reciprocal quotient out of range");

  a_dinv_range: assert property (@(posedge clk) disable iff (rst)
    sv[ST-1] && sd[ST-1].cmd == rds_pkg::CMD_DINV && sd[ST-1].idx == 2'd0 && !sd[ST-1].vone
    |-> quo[0][64:63] == '0)
    else $error("inverse derivative quotient out of range");

endmodule
